// ----- sv/timer_job_priority_table_defines.svh -----
// Assertion helpers for the checker file.
`ifndef TIMER_JOB_PRIORITY_TABLE_DEFINES_SVH
`define TIMER_JOB_PRIORITY_TABLE_DEFINES_SVH

// Concurrent assertion on a named clock, disabled while reset is high.
`define TJPT_ASSERT_CLK(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Same, on the usual clk and rst of the enclosing module.
`define TJPT_ASSERT(label, prop, msg) `TJPT_ASSERT_CLK(label, clk, rst, prop, msg)

`endif

// ----- sv/tjpt_pkg.sv -----
`timescale 1ns / 1ps

package tjpt_pkg;

  // Default sizes handed to the top level
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 16;
  localparam int TIME_WIDTH_DEF  = 32;

  // Most fired jobs one pop may return
  localparam int MAX_RESULTS = 16;

  // Fixed field widths on the ports
  localparam int FUNC_W      = 2;
  localparam int KIND_W      = 2;
  localparam int JOB_ID_W    = 16;
  localparam int IN_TIME_W   = 32;
  localparam int FIRED_CNT_W = 5;
  localparam int IN_DATA_W   = 80;
  localparam int OUT_DATA_W  = 24;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  typedef struct packed {
    logic free_found;
    logic match_found;
    logic best_found;
  } scan_flags_t;

endpackage

// ----- sv/tjpt_mem.sv -----
`timescale 1ns / 1ps

module tjpt_mem
  import tjpt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  logic [WIDTH-1:0]               wr_data,
  input  logic                           rd_en,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic [WIDTH-1:0]               rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/tjpt_scan.sv -----
`timescale 1ns / 1ps

// Compare unit fed one slot per cycle during a table sweep. Tracks the
// first free slot, the slot holding the key id and the earliest job, and
// applies a pending rank decrement left by the last drop.
module tjpt_scan
  import tjpt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  localparam int AW    = $clog2(TABLE_DEPTH),
  localparam int RK_W  = $clog2(TABLE_DEPTH + 1),
  localparam int KEY_W = (ID_WIDTH > JOB_ID_W) ? ID_WIDTH : JOB_ID_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clr,
  input  logic                  vld,
  input  logic [AW-1:0]         idx,
  input  logic                  vbit,
  input  logic [ID_WIDTH-1:0]   id,
  input  logic [TIME_WIDTH-1:0] expv,
  input  logic [RK_W-1:0]       rank,
  input  logic [KEY_W-1:0]      key,
  input  logic                  pend,
  input  logic [RK_W-1:0]       pend_r,
  output logic                  wb_en,
  output logic [RK_W-1:0]       wb_rank,
  output scan_flags_t           flags,
  output logic [AW-1:0]         free_slot,
  output logic [AW-1:0]         match_slot,
  output logic [RK_W-1:0]       match_rank,
  output logic [AW-1:0]         best_slot,
  output logic [ID_WIDTH-1:0]   best_id,
  output logic [TIME_WIDTH-1:0] best_exp,
  output logic [RK_W-1:0]       best_rank
);

  logic            shift_down;
  logic [RK_W-1:0] adj_rank;
  logic            is_match;
  logic            is_better;

  assign shift_down = pend && vbit && (rank > pend_r);
  assign adj_rank   = shift_down ? RK_W'(rank - 1'b1) : rank;
  assign wb_en      = vld && shift_down;
  assign wb_rank    = adj_rank;
  assign is_match   = vbit && (KEY_W'(id) == key);
  // earliest expiry wins, ties go to the job added first
  assign is_better  = vbit && (!flags.best_found || (expv < best_exp) ||
                      ((expv == best_exp) && (adj_rank < best_rank)));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      flags <= '0;
    end else if (vld) begin
      if (!vbit && !flags.free_found) begin
        flags.free_found <= 1'b1;
        free_slot        <= idx;
      end
      if (is_match && !flags.match_found) begin
        flags.match_found <= 1'b1;
        match_slot        <= idx;
        match_rank        <= adj_rank;
      end
      if (is_better) begin
        flags.best_found <= 1'b1;
        best_slot        <= idx;
        best_id          <= id;
        best_exp         <= expv;
        best_rank        <= adj_rank;
      end
    end
  end

endmodule

// ----- sv/timer_job_priority_table.sv -----
`timescale 1ns / 1ps

// Channel  Dir  tdata (low bit up)                         tuser        tlast
// s_*      in   expire_time[31:0] job_handle[47:32]        func[1:0]    -
//               now_time[79:48]
// m_*      out  job_id[15:0] ok[16] fired_count[21:17]     result_kind  last
//               pad[23:22]
//
// Every add, remove and pop sweeps the slot memory through its single read
// port, one slot a cycle. Add: one sweep, plus one sweep per nonzero id tried
// while advancing the next free id. Remove: one sweep. Pop: one sweep per
// fired job plus a final one, skipped when the pop limit is reached. Clear
// needs no sweep. s_tready is high only while idle; m_tready low holds the
// output word and stalls the sequencer at its next result. rst is synchronous;
// it empties the table and sets the next id to one.
module timer_job_priority_table
  import tjpt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // expire_time, job_handle, now_time
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // func
  input  logic [FUNC_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // job_id, ok, fired_count, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // result_kind
  output logic [KIND_W-1:0]     m_tuser,
  output logic                  m_tlast
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int RK_W   = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W  = (ID_WIDTH > JOB_ID_W) ? ID_WIDTH : JOB_ID_W;
  localparam int WORD_W = ID_WIDTH + TIME_WIDTH + RK_W;
  localparam int TRY_W  = $clog2(TABLE_DEPTH + 2);

  localparam logic [AW-1:0]          LAST_IDX  = AW'(TABLE_DEPTH - 1);
  localparam logic [TRY_W-1:0]       LAST_TRY  = TRY_W'(TABLE_DEPTH + 1);
  localparam logic [FIRED_CNT_W-1:0] FIRED_MAX = FIRED_CNT_W'(MAX_RESULTS);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SWEEP    = 3'd1;
  localparam logic [2:0] S_DECIDE   = 3'd2;
  localparam logic [2:0] S_ADV      = 3'd3;
  localparam logic [2:0] S_POP_NEXT = 3'd4;
  localparam logic [2:0] S_PUSH     = 3'd5;

  logic [2:0]             state;
  logic [FUNC_W-1:0]      func_q;
  logic [TIME_WIDTH-1:0]  exp_q;
  logic [JOB_ID_W-1:0]    handle_q;
  logic [TIME_WIDTH-1:0]  now_q;
  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [RK_W-1:0]        held_cnt;
  logic [ID_WIDTH-1:0]    next_id;
  logic [ID_WIDTH-1:0]    cand;
  logic [TRY_W-1:0]       tries;
  logic                   adv_phase;
  logic                   pend;
  logic [RK_W-1:0]        pend_r;
  logic [AW-1:0]          scan_idx;
  logic                   issue_done;
  logic                   p_vld;
  logic [AW-1:0]          p_idx;
  logic [FIRED_CNT_W-1:0] fired_n;
  logic [ID_WIDTH-1:0]    held_id;

  logic [KIND_W-1:0]      res_kind;
  logic [JOB_ID_W-1:0]    res_id;
  logic                   res_ok;
  logic [FIRED_CNT_W-1:0] res_cnt;
  logic                   res_last;

  logic                   out_valid;
  logic [KIND_W-1:0]      out_kind;
  logic [JOB_ID_W-1:0]    out_id;
  logic                   out_ok;
  logic [FIRED_CNT_W-1:0] out_cnt;
  logic                   out_last;

  logic                   rd_en;
  logic [WORD_W-1:0]      rd_word;
  logic [ID_WIDTH-1:0]    rd_id;
  logic [TIME_WIDTH-1:0]  rd_exp;
  logic [RK_W-1:0]        rd_rank;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [WORD_W-1:0]      wr_data;
  logic                   add_wr;
  logic                   add_ok;
  logic                   fire;
  logic                   push_load;
  logic                   scan_clr;
  logic [KEY_W-1:0]       key;

  logic                   wb_en;
  logic [RK_W-1:0]        wb_rank;
  scan_flags_t            flags;
  logic [AW-1:0]          free_slot;
  logic [AW-1:0]          match_slot;
  logic [RK_W-1:0]        match_rank;
  logic [AW-1:0]          best_slot;
  logic [ID_WIDTH-1:0]    best_id;
  logic [TIME_WIDTH-1:0]  best_exp;
  logic [RK_W-1:0]        best_rank;

  assign s_tready = (state == S_IDLE);
  assign rd_en    = (state == S_SWEEP) && !issue_done;
  assign scan_clr = (state == S_IDLE) || (state == S_ADV) || (state == S_POP_NEXT);
  assign key      = (func_q == FUNC_REMOVE) ? KEY_W'(handle_q) : KEY_W'(cand);

  assign {rd_id, rd_exp, rd_rank} = rd_word;

  assign add_ok = flags.free_found && (cand != '0) && !flags.match_found;
  assign add_wr = (state == S_DECIDE) && (func_q == FUNC_ADD) && !adv_phase && add_ok;
  assign fire   = flags.best_found && (best_exp <= now_q);

  assign wr_en   = add_wr || wb_en;
  assign wr_addr = add_wr ? free_slot : p_idx;
  assign wr_data = add_wr ? {cand, exp_q, held_cnt} : {rd_id, rd_exp, wb_rank};

  assign push_load = (state == S_PUSH) && (!out_valid || m_tready);

  tjpt_mem #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx),
    .rd_data (rd_word)
  );

  tjpt_scan #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_WIDTH    (ID_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .clr        (scan_clr),
    .vld        (p_vld),
    .idx        (p_idx),
    .vbit       (slot_valid[p_idx]),
    .id         (rd_id),
    .expv       (rd_exp),
    .rank       (rd_rank),
    .key        (key),
    .pend       (pend),
    .pend_r     (pend_r),
    .wb_en      (wb_en),
    .wb_rank    (wb_rank),
    .flags      (flags),
    .free_slot  (free_slot),
    .match_slot (match_slot),
    .match_rank (match_rank),
    .best_slot  (best_slot),
    .best_id    (best_id),
    .best_exp   (best_exp),
    .best_rank  (best_rank)
  );

  // read issue, registered for the compare unit in step with the memory read data
  always_ff @(posedge clk) begin
    p_vld <= rd_en && !rst;
    p_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      held_cnt   <= '0;
      next_id    <= ID_WIDTH'(1);
      pend       <= 1'b0;
      adv_phase  <= 1'b0;
      issue_done <= 1'b1;
      scan_idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func_q    <= s_tuser;
            exp_q     <= TIME_WIDTH'(s_tdata[31:0]);
            handle_q  <= s_tdata[47:32];
            now_q     <= TIME_WIDTH'(s_tdata[79:48]);
            cand      <= next_id;
            fired_n   <= '0;
            adv_phase <= 1'b0;
            if (s_tuser == FUNC_CLEAR) begin
              slot_valid <= '0;
              held_cnt   <= '0;
              pend       <= 1'b0;
              {res_kind, res_id, res_ok, res_cnt, res_last} <=
                {KIND_NONE, JOB_ID_W'(0), 1'b1, FIRED_CNT_W'(0), 1'b1};
              state <= S_PUSH;
            end else begin
              scan_idx   <= '0;
              issue_done <= 1'b0;
              state      <= S_SWEEP;
            end
          end
        end

        S_SWEEP: begin
          if (rd_en) begin
            if (scan_idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              scan_idx <= scan_idx + 1'b1;
            end
          end
          if (p_vld && (p_idx == LAST_IDX)) begin
            pend  <= 1'b0;
            state <= S_DECIDE;
          end
        end

        S_DECIDE: begin
          unique case (func_q)
            FUNC_ADD: begin
              if (adv_phase) begin
                if (!flags.match_found) begin
                  next_id   <= cand;
                  adv_phase <= 1'b0;
                  state     <= S_PUSH;
                end else if (tries == LAST_TRY) begin
                  next_id   <= cand + 1'b1;
                  adv_phase <= 1'b0;
                  state     <= S_PUSH;
                end else begin
                  cand  <= cand + 1'b1;
                  tries <= tries + 1'b1;
                  state <= S_ADV;
                end
              end else if (add_ok) begin
                slot_valid[free_slot] <= 1'b1;
                held_cnt  <= held_cnt + 1'b1;
                {res_kind, res_id, res_ok, res_cnt, res_last} <=
                  {KIND_ADD, JOB_ID_W'(cand), 1'b1, FIRED_CNT_W'(0), 1'b1};
                cand      <= cand + 1'b1;
                tries     <= '0;
                adv_phase <= 1'b1;
                state     <= S_ADV;
              end else begin
                {res_kind, res_id, res_ok, res_cnt, res_last} <=
                  {KIND_ADD, JOB_ID_W'(0), 1'b0, FIRED_CNT_W'(0), 1'b1};
                state <= S_PUSH;
              end
            end
            FUNC_REMOVE: begin
              if (flags.match_found) begin
                slot_valid[match_slot] <= 1'b0;
                pend     <= 1'b1;
                pend_r   <= match_rank;
                held_cnt <= held_cnt - 1'b1;
              end
              {res_kind, res_id, res_ok, res_cnt, res_last} <=
                {KIND_REMOVE, handle_q, flags.match_found, FIRED_CNT_W'(0), 1'b1};
              state <= S_PUSH;
            end
            FUNC_POP: begin
              if (fire) begin
                slot_valid[best_slot] <= 1'b0;
                pend     <= 1'b1;
                pend_r   <= best_rank;
                held_cnt <= held_cnt - 1'b1;
                held_id  <= best_id;
                fired_n  <= fired_n + 1'b1;
                // the previous fired job is known not to be last now
                if (fired_n != '0) begin
                  {res_kind, res_id, res_ok, res_cnt, res_last} <=
                    {KIND_FIRED, JOB_ID_W'(held_id), 1'b1, fired_n, 1'b0};
                  state <= S_PUSH;
                end else begin
                  state <= S_POP_NEXT;
                end
              end else if (fired_n == '0) begin
                {res_kind, res_id, res_ok, res_cnt, res_last} <=
                  {KIND_NONE, JOB_ID_W'(0), 1'b0, FIRED_CNT_W'(0), 1'b1};
                state <= S_PUSH;
              end else begin
                {res_kind, res_id, res_ok, res_cnt, res_last} <=
                  {KIND_FIRED, JOB_ID_W'(held_id), 1'b1, fired_n, 1'b1};
                state <= S_PUSH;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        S_ADV: begin
          // id zero is never handed out: skip it without a sweep
          if (cand == '0) begin
            if (tries == LAST_TRY) begin
              next_id   <= cand + 1'b1;
              adv_phase <= 1'b0;
              state     <= S_PUSH;
            end else begin
              cand  <= cand + 1'b1;
              tries <= tries + 1'b1;
            end
          end else begin
            scan_idx   <= '0;
            issue_done <= 1'b0;
            state      <= S_SWEEP;
          end
        end

        S_POP_NEXT: begin
          if (fired_n == FIRED_MAX) begin
            {res_kind, res_id, res_ok, res_cnt, res_last} <=
              {KIND_FIRED, JOB_ID_W'(held_id), 1'b1, fired_n, 1'b1};
            state <= S_PUSH;
          end else begin
            scan_idx   <= '0;
            issue_done <= 1'b0;
            state      <= S_SWEEP;
          end
        end

        S_PUSH: begin
          if (push_load) begin
            state <= res_last ? S_IDLE : S_POP_NEXT;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_load) begin
      out_kind <= res_kind;
      out_id   <= res_id;
      out_ok   <= res_ok;
      out_cnt  <= res_cnt;
      out_last <= res_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_cnt, out_ok, out_id};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

// ----- sv/tjpt_checker.sv -----
`timescale 1ns / 1ps
`include "timer_job_priority_table_defines.svh"

module tjpt_checker
  import tjpt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [KIND_W-1:0]     m_tuser,
  input logic                  m_tlast
);

  localparam int WORD_W = OUT_DATA_W + KIND_W + 1;

  logic [FIRED_CNT_W-1:0] cnt;
  logic                   in_acc;
  logic                   out_stall;
  logic                   fired_word;
  logic [WORD_W-1:0]      out_word;

  assign cnt        = m_tdata[21:17];
  assign in_acc     = s_tvalid && s_tready;
  assign out_stall  = m_tvalid && !m_tready;
  assign fired_word = m_tvalid && (m_tuser == KIND_FIRED);
  assign out_word   = {m_tlast, m_tuser, m_tdata};

  // hold a stalled output word
  `TJPT_ASSERT(a_out_hold, out_stall |=> m_tvalid && $stable(out_word), "stalled word changed")

  // one word at a time: busy right after an accept
  `TJPT_ASSERT(a_busy_after_accept, in_acc |=> !s_tready, "input accepted while busy")

  `TJPT_ASSERT(a_fired_count, fired_word |-> cnt != '0 && m_tdata[16], "fired word without count")

  `TJPT_ASSERT(a_single_answer, m_tvalid && !fired_word |-> m_tlast && cnt == '0, "bad answer word")

endmodule

bind timer_job_priority_table tjpt_checker u_tjpt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- test/timer_job_priority_table_test.sv -----
`timescale 1ns / 1ps

module timer_job_priority_table_test;
  import tjpt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 2 * (TABLE_DEPTH_DEF + 2) + 10;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    logic [KIND_W-1:0]      kind;
    logic [JOB_ID_W-1:0]    job_id;
    logic                   ok;
    logic [FIRED_CNT_W-1:0] count;
    logic                   last;
  } answer_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [FUNC_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  // Shadow copy of the job table
  logic                 held [TABLE_DEPTH_DEF];
  logic [JOB_ID_W-1:0]  held_id [TABLE_DEPTH_DEF];
  logic [IN_TIME_W-1:0] held_expiry [TABLE_DEPTH_DEF];
  logic [15:0]          held_rank [TABLE_DEPTH_DEF];
  logic [JOB_ID_W-1:0]  id_cursor = 16'd1;
  logic [15:0]          rank_count = '0;

  answer_t pending_answers[$];
  answer_t want_ans;

  int          error_count = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          send_gaps = 1'b0;
  bit          recv_stalls = 1'b0;
  logic [31:0] time_base = '0;

  timer_job_priority_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver backpressure in bursts of random length while recv_stalls is set
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      m_tready = 1'b0;
    end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected word kind %0d id %0d ok %0d count %0d last %0d",
                   $time, m_tuser, m_tdata[15:0], m_tdata[16], m_tdata[21:17], m_tlast);
      end else begin
        want_ans = pending_answers.pop_front();
        if (m_tuser !== want_ans.kind || m_tdata[15:0] !== want_ans.job_id ||
            m_tdata[16] !== want_ans.ok || m_tdata[21:17] !== want_ans.count ||
            m_tlast !== want_ans.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"%0t: expected kind %0d id %0d ok %0d count %0d last %0d,",
                      " got kind %0d id %0d ok %0d count %0d last %0d"},
                     $time, want_ans.kind, want_ans.job_id, want_ans.ok, want_ans.count,
                     want_ans.last, m_tuser, m_tdata[15:0], m_tdata[16], m_tdata[21:17],
                     m_tlast);
        end
      end
    end
  end

  function automatic void push_answer(input logic [KIND_W-1:0] kind,
                                      input logic [JOB_ID_W-1:0] job_id, input logic ok,
                                      input logic [FIRED_CNT_W-1:0] count, input logic last);
    answer_t a;
    a.kind = kind;
    a.job_id = job_id;
    a.ok = ok;
    a.count = count;
    a.last = last;
    pending_answers.push_back(a);
  endfunction

  function automatic bit id_held(input logic [JOB_ID_W-1:0] id);
    int i;
    for (i = 0; i < TABLE_DEPTH_DEF; i++)
      if (held[i] && held_id[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  // Free a slot and close the gap it leaves in the add order
  function automatic void drop_job(input int slot);
    int i;
    held[slot] = 1'b0;
    for (i = 0; i < TABLE_DEPTH_DEF; i++)
      if (held[i] && held_rank[i] > held_rank[slot]) held_rank[i]--;
    if (rank_count > 0) rank_count--;
  endfunction

  function automatic void update_table(input logic [FUNC_W-1:0] op,
                                       input logic [IN_TIME_W-1:0] expiry,
                                       input logic [JOB_ID_W-1:0] handle,
                                       input logic [IN_TIME_W-1:0] now);
    int slot;
    int best;
    int n;
    int i;
    logic [JOB_ID_W-1:0] c;
    answer_t fired;
    slot = -1;
    n = 0;
    fired = '{default: '0};
    case (op)
      FUNC_ADD: begin
        for (i = 0; i < TABLE_DEPTH_DEF; i++)
          if (!held[i] && slot < 0) slot = i;
        if (slot < 0 || id_cursor == 0 || id_held(id_cursor)) begin
          push_answer(KIND_ADD, '0, 1'b0, '0, 1'b1);
        end else begin
          held[slot] = 1'b1;
          held_id[slot] = id_cursor;
          held_expiry[slot] = expiry;
          held_rank[slot] = rank_count;
          rank_count++;
          push_answer(KIND_ADD, id_cursor, 1'b1, '0, 1'b1);
          // advance past zero and ids in use, new one included
          c = id_cursor + 1'b1;
          for (i = 0; i < TABLE_DEPTH_DEF + 2; i++)
            if (c == 0 || id_held(c)) c = c + 1'b1;
          id_cursor = c;
        end
      end
      FUNC_REMOVE: begin
        for (i = 0; i < TABLE_DEPTH_DEF; i++)
          if (slot < 0 && held[i] && held_id[i] == handle) slot = i;
        if (slot >= 0) drop_job(slot);
        push_answer(KIND_REMOVE, handle, slot >= 0, '0, 1'b1);
      end
      FUNC_POP: begin
        while (n < MAX_RESULTS) begin
          best = -1;
          for (i = 0; i < TABLE_DEPTH_DEF; i++)
            if (held[i] && (best < 0 || held_expiry[i] < held_expiry[best] ||
                (held_expiry[i] == held_expiry[best] && held_rank[i] < held_rank[best])))
              best = i;
          if (best < 0 || held_expiry[best] > now) break;
          if (n > 0) pending_answers.push_back(fired);
          fired.kind = KIND_FIRED;
          fired.job_id = held_id[best];
          fired.ok = 1'b1;
          fired.count = FIRED_CNT_W'(n + 1);
          fired.last = 1'b0;
          drop_job(best);
          n++;
        end
        if (n == 0) begin
          push_answer(KIND_NONE, '0, 1'b0, '0, 1'b1);
        end else begin
          fired.last = 1'b1;
          pending_answers.push_back(fired);
        end
      end
      FUNC_CLEAR: begin
        for (i = 0; i < TABLE_DEPTH_DEF; i++) held[i] = 1'b0;
        rank_count = '0;
        push_answer(KIND_NONE, '0, 1'b1, '0, 1'b1);
      end
    endcase
  endfunction

  // Present one word at a falling edge and hold it until taken
  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [IN_TIME_W-1:0] expiry,
                         input logic [JOB_ID_W-1:0] handle, input logic [IN_TIME_W-1:0] now);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tuser = op;
    s_tdata = {now, handle, expiry};
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    update_table(op, expiry, handle, now);
    @(negedge clk);
  endtask

  task automatic hold_until_drained;
    s_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_basic_ops;
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
    // empty table corners
    send_op(FUNC_POP, $urandom, JOB_ID_W'($urandom), 32'd0);
    send_op(FUNC_REMOVE, $urandom, 16'd0, $urandom);
    send_op(FUNC_REMOVE, $urandom, 16'hFFFF, $urandom);
    send_op(FUNC_CLEAR, $urandom, JOB_ID_W'($urandom), $urandom);
    send_op(FUNC_ADD, 32'hFFFF_FFFF, JOB_ID_W'($urandom), $urandom);
    send_op(FUNC_ADD, 32'd0, JOB_ID_W'($urandom), $urandom);
    send_op(FUNC_ADD, 32'd100, JOB_ID_W'($urandom), $urandom);
    send_op(FUNC_ADD, 32'd100, JOB_ID_W'($urandom), $urandom);
    send_op(FUNC_ADD, 32'd50, JOB_ID_W'($urandom), $urandom);
    send_op(FUNC_REMOVE, $urandom, 16'd3, $urandom);
    send_op(FUNC_REMOVE, $urandom, 16'd3, $urandom);
    send_op(FUNC_POP, $urandom, JOB_ID_W'($urandom), 32'd99);
    send_op(FUNC_ADD, 32'd100, JOB_ID_W'($urandom), $urandom);
    // equal expiry: fire in add order
    send_op(FUNC_POP, $urandom, JOB_ID_W'($urandom), 32'd100);
    send_op(FUNC_POP, $urandom, JOB_ID_W'($urandom), 32'hFFFF_FFFF);
    send_op(FUNC_ADD, 32'd7, JOB_ID_W'($urandom), $urandom);
    send_op(FUNC_CLEAR, $urandom, JOB_ID_W'($urandom), $urandom);
    send_op(FUNC_REMOVE, $urandom, 16'd9, $urandom);
  endtask

  task automatic test_full_table;
    int k;
    hold_until_drained();
    // last add finds the table full
    for (k = 0; k < TABLE_DEPTH_DEF + 1; k++)
      send_op(FUNC_ADD, $urandom_range(0, 3), JOB_ID_W'($urandom), $urandom);
    send_op(FUNC_POP, $urandom, JOB_ID_W'($urandom), 32'hFFFF_FFFF);
    send_op(FUNC_ADD, 32'd5, JOB_ID_W'($urandom), $urandom);
    send_op(FUNC_CLEAR, $urandom, JOB_ID_W'($urandom), $urandom);
  endtask

  task automatic test_random_traffic(input int count, input bit gaps, input bit stalls);
    int k;
    int i;
    int roll;
    int held_ids[$];
    logic [FUNC_W-1:0]    op;
    logic [IN_TIME_W-1:0] expiry;
    logic [IN_TIME_W-1:0] now;
    logic [JOB_ID_W-1:0]  handle;
    send_gaps = gaps;
    recv_stalls = stalls;
    for (k = 0; k < count; k++) begin
      expiry = $urandom;
      now = $urandom;
      handle = JOB_ID_W'($urandom);
      if ($urandom_range(0, 24) == 0) time_base = $urandom;
      else time_base = time_base + $urandom_range(0, 20);
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        op = FUNC_ADD;
        // coarse grid so that equal expiry times come up often
        if ($urandom_range(0, 9) != 0) expiry = time_base + 4 * $urandom_range(0, 15);
      end else if (roll < 65) begin
        op = FUNC_REMOVE;
        held_ids.delete();
        for (i = 0; i < TABLE_DEPTH_DEF; i++)
          if (held[i]) held_ids.push_back(held_id[i]);
        if (held_ids.size() != 0 && $urandom_range(0, 3) != 0)
          handle = JOB_ID_W'(held_ids[$urandom_range(0, held_ids.size() - 1)]);
        else if ($urandom_range(0, 1) == 0)
          handle = JOB_ID_W'(id_cursor - $urandom_range(0, 20));
      end else if (roll < 95) begin
        op = FUNC_POP;
        if ($urandom_range(0, 9) != 0) now = time_base + $urandom_range(0, 60) - 10;
      end else begin
        op = FUNC_CLEAR;
      end
      send_op(op, expiry, handle, now);
    end
  endtask

  initial begin
    for (int i = 0; i < TABLE_DEPTH_DEF; i++) held[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_basic_ops();
    test_full_table();
    time_base = $urandom;
    test_random_traffic(110, 1'b1, 1'b1);
    hold_until_drained();
    test_random_traffic(70, 1'b1, 1'b0);
    test_random_traffic(70, 1'b0, 1'b1);
    test_random_traffic(50, 1'b0, 1'b0);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/tjpt_pkg.sv
sv/tjpt_mem.sv
sv/tjpt_scan.sv
sv/timer_job_priority_table.sv
sv/tjpt_checker.sv
test/timer_job_priority_table_test.sv
